@@ rtl/cset_pkg.sv @@
// Package for the call stack exclusive timer.
// Holds event and status codes, the result record and the saturating adder.
// No dependencies.
package cset_pkg;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_FULL     = 3'd3,
    ST_REVERSED = 3'd4
  } status_t;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    status_t     status;
    logic [6:0]  id;
    logic [31:0] call;
    logic [31:0] total;
    logic [6:0]  level;
  } out_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

endpackage

@@ rtl/call_stack_exclusive_timer.sv @@
// Call stack exclusive timer: frame memory, totals memory, three-stage pipe
// and result queue. Depends on cset_pkg.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------------
//  event   | event_valid / event_stall   | action, func_id, timestamp
//  result  | result_valid / result_stall | status, result_id, call_time,
//          |                             | total_time, stack_level
//
// Flow: one event item per cycle while event_stall is low; the y and z registers carry
//   it to the queue. Throughput is set by the stack top registers, which decide every
//   start and end in the accept cycle, and by the registered totals memory read.
// Reset: clears the stack pointer and the pipe, then sweeps all NUM_FUNCS entries
//   of the totals memory to zero with event_stall high.
// Stalls: a four-item result queue parts the two sides; event_stall rises during the
//   totals sweep and when the queue plus the items in flight would fill it.
module call_stack_exclusive_timer #(
  parameter int NUM_FUNCS   = 128,
  parameter int STACK_DEPTH = 64,
  parameter int TIME_BITS   = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        event_valid,
  output logic        event_stall,
  input  logic [1:0]  action,
  input  logic [6:0]  func_id,
  input  logic [30:0] timestamp,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [6:0]  result_id,
  output logic [31:0] call_time,
  output logic [31:0] total_time,
  output logic [6:0]  stack_level
);

  localparam int SLOT_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int FI_W   = $clog2(STACK_DEPTH);
  localparam int SPAN_W = TIME_BITS + 1;

  // One stack frame; the top frame lives in registers, the rest in fmem.
  typedef struct packed {
    logic [6:0]           id;
    logic [TIME_BITS-1:0] start;
    logic [31:0]          child;
  } frame_t;

  // Item after the accept stage.
  typedef struct packed {
    logic                pop;
    logic                parent;
    cset_pkg::status_t   status;
    logic [6:0]          id;
    logic [SLOT_W-1:0]   slot;
    logic [SP_W-1:0]     level;
    logic [SPAN_W-1:0]   span;
    logic [31:0]         parent_child;
  } ystage_t;

  // Item after the exclusive-time stage.
  typedef struct packed {
    cset_pkg::status_t   status;
    logic [6:0]          id;
    logic [SLOT_W-1:0]   slot;
    logic [SP_W-1:0]     level;
    logic [31:0]         call;
    logic [31:0]         total;
  } zstage_t;

  // ---------------------------------------------------------------- state
  logic [SP_W-1:0]      sp, sp_next;
  logic [6:0]           top_id, top_id_next;
  logic [TIME_BITS-1:0] top_start, top_start_next;
  logic [31:0]          tos_child;

  frame_t               fmem [STACK_DEPTH];
  frame_t               f_q, f_fwd_data, nos, f_wdata;
  logic                 f_fwd, f_we;
  logic [FI_W-1:0]      f_raddr, f_waddr;

  logic [31:0]          tmem [NUM_FUNCS];
  logic [31:0]          t_q, t_fwd_data, t_wdata;
  logic                 t_fwd, t_we;
  logic [SLOT_W-1:0]    t_waddr;
  logic                 last_valid;
  logic [SLOT_W-1:0]    last_slot;
  logic [31:0]          last_total;

  logic                 clear_active;
  logic [SLOT_W-1:0]    clr_addr;

  logic                 y_valid, z_valid;
  ystage_t              y_item;
  zstage_t              z_item;

  cset_pkg::out_t              out_q [cset_pkg::OUT_DEPTH];
  logic [cset_pkg::OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cset_pkg::OUT_CNT_W-1:0] out_cnt;
  logic [cset_pkg::OUT_CNT_W:0]   occ;

  // ---------------------------------------------------------------- accept stage
  logic                 accept;
  logic [TIME_BITS-1:0] ts;
  logic [6:0]           slot_rem;
  logic [SLOT_W-1:0]    slot;
  cset_pkg::status_t    x_status;
  logic                 do_push, do_pop;
  logic [SPAN_W-1:0]    x_span;

  assign occ         = {1'b0, out_cnt} + (cset_pkg::OUT_CNT_W + 1)'(y_valid)
                       + (cset_pkg::OUT_CNT_W + 1)'(z_valid);
  assign event_stall = clear_active || (occ >= (cset_pkg::OUT_CNT_W + 1)'(cset_pkg::OUT_DEPTH));
  assign accept      = event_valid && !event_stall;
  assign ts          = TIME_BITS'(timestamp);

  // Reduce the id into the totals range, one restoring step per bit.
  always_comb begin
    slot_rem = func_id;
    for (int k = 6; k >= 0; k--) begin
      if ({11'd0, slot_rem} >= (18'(NUM_FUNCS) << k)) begin
        slot_rem = slot_rem - 7'(18'(NUM_FUNCS) << k);
      end
    end
  end
  assign slot = SLOT_W'(slot_rem);

  // Second frame from the top, with the push written in the same edge forwarded.
  assign nos = f_fwd ? f_fwd_data : f_q;

  always_comb begin
    x_status = cset_pkg::ST_OK;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    case (action)
      cset_pkg::ACT_START: begin
        if (sp == SP_W'(STACK_DEPTH)) x_status = cset_pkg::ST_FULL;
        else do_push = 1'b1;
      end
      cset_pkg::ACT_END: begin
        if (sp == '0) x_status = cset_pkg::ST_EMPTY;
        else if (top_id != func_id) x_status = cset_pkg::ST_MISMATCH;
        else if (ts < top_start) x_status = cset_pkg::ST_REVERSED;
        else do_pop = 1'b1;
      end
      default: ;
    endcase
  end

  assign x_span = {1'b0, ts} - {1'b0, top_start} + SPAN_W'(1);

  always_comb begin
    sp_next        = sp;
    top_id_next    = top_id;
    top_start_next = top_start;
    if (accept && do_push) begin
      sp_next        = sp + SP_W'(1);
      top_id_next    = func_id;
      top_start_next = ts;
    end else if (accept && do_pop) begin
      sp_next        = sp - SP_W'(1);
      top_id_next    = nos.id;
      top_start_next = nos.start;
    end
  end

  // ---------------------------------------------------------------- exclusive-time stage
  logic [31:0] y_span32, y_call, y_child_new, tos_child_eff;
  logic        y_upd;

  assign y_span32    = (|(y_item.span >> 32)) ? cset_pkg::SAT32 : 32'(y_item.span);
  assign y_call      = (y_item.pop && (y_span32 > tos_child)) ? (y_span32 - tos_child) : '0;
  assign y_upd       = y_valid && y_item.pop && y_item.parent;
  assign y_child_new = cset_pkg::sat_add32(y_item.parent_child, y_span32);
  // A push in the same cycle spills the parent with its fresh children's time.
  assign tos_child_eff = y_upd ? y_child_new : tos_child;

  // ---------------------------------------------------------------- frame memory
  assign f_we    = accept && do_push && (sp != '0);
  assign f_waddr = FI_W'(sp - SP_W'(1));
  assign f_wdata = '{id: top_id, start: top_start, child: tos_child_eff};
  assign f_raddr = (sp_next >= SP_W'(2)) ? FI_W'(sp_next - SP_W'(2)) : '0;

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    f_q        <= fmem[f_raddr];
    f_fwd_data <= f_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_fwd <= 1'b0;
    end else begin
      f_fwd <= f_we && (f_waddr == f_raddr);
    end
  end

  // ---------------------------------------------------------------- stack registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    top_id    <= top_id_next;
    top_start <= top_start_next;
    if (accept && do_push) tos_child <= '0;
    else if (y_upd) tos_child <= y_child_new;
  end

  // ---------------------------------------------------------------- pipe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
      z_valid <= 1'b0;
    end else begin
      y_valid <= accept;
      z_valid <= y_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_item.pop          <= do_pop;
      y_item.parent       <= sp > SP_W'(1);
      y_item.status       <= x_status;
      y_item.id           <= func_id;
      y_item.slot         <= slot;
      y_item.level        <= sp_next;
      y_item.span         <= x_span;
      y_item.parent_child <= nos.child;
    end
    z_item.status <= y_item.status;
    z_item.id     <= y_item.id;
    z_item.slot   <= y_item.slot;
    z_item.level  <= y_item.level;
    z_item.call   <= y_call;
    z_item.total  <= t_fwd ? t_fwd_data : t_q;
  end

  // ---------------------------------------------------------------- totals memory
  logic [31:0] z_operand, z_total_new;

  // The latest write of all wins when it hits this item's slot.
  assign z_operand   = (last_valid && (last_slot == z_item.slot)) ? last_total : z_item.total;
  assign z_total_new = cset_pkg::sat_add32(z_operand, z_item.call);

  assign t_we    = clear_active || z_valid;
  assign t_waddr = clear_active ? clr_addr : z_item.slot;
  assign t_wdata = clear_active ? '0 : z_total_new;

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_waddr] <= t_wdata;
    t_q        <= tmem[slot];
    t_fwd_data <= t_wdata;
    if (t_we) begin
      last_slot  <= t_waddr;
      last_total <= t_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_fwd        <= 1'b0;
      last_valid   <= 1'b0;
      clear_active <= 1'b1;
      clr_addr     <= '0;
    end else begin
      t_fwd <= t_we && (t_waddr == slot);
      if (t_we) last_valid <= 1'b1;
      if (clear_active) begin
        clr_addr <= clr_addr + SLOT_W'(1);
        if (clr_addr == SLOT_W'(NUM_FUNCS - 1)) clear_active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result queue
  logic out_push, out_pop;

  assign out_push = z_valid;
  assign out_pop  = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_q[wr_ptr] <= '{status: z_item.status, id: z_item.id, call: z_item.call,
                         total: z_total_new, level: 7'(z_item.level)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      out_cnt <= '0;
    end else begin
      if (out_push) wr_ptr <= wr_ptr + cset_pkg::OUT_PTR_W'(1);
      if (out_pop) rd_ptr <= rd_ptr + cset_pkg::OUT_PTR_W'(1);
      out_cnt <= out_cnt + cset_pkg::OUT_CNT_W'(out_push) - cset_pkg::OUT_CNT_W'(out_pop);
    end
  end

  assign result_valid = (out_cnt != '0);
  assign status       = out_q[rd_ptr].status;
  assign result_id    = out_q[rd_ptr].id;
  assign call_time    = out_q[rd_ptr].call;
  assign total_time   = out_q[rd_ptr].total;
  assign stack_level  = out_q[rd_ptr].level;

  // ---------------------------------------------------------------- checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= cset_pkg::OUT_CNT_W'(cset_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occ <= (cset_pkg::OUT_CNT_W + 1)'(cset_pkg::OUT_DEPTH))
    else $error("items in flight exceed queue room");

  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    clear_active |-> !accept)
    else $error("event taken during totals sweep");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

endmodule
